// ----- design/mm_pkg.sv -----
`timescale 1ns / 1ps

package mm_pkg;

   // Size bounds and element width
   localparam int MAX_DIM      = 8;
   localparam int ELEMENT_BITS = 16;
   localparam int IDX_BITS     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int STORE_DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
   localparam int PROD_BITS    = 2 * ELEMENT_BITS;
   localparam int OUT_BITS     = 40;

   typedef logic [1:0]                    cmd_type;
   typedef logic [2:0]                    pos_type;
   typedef logic signed [15:0]            value_type;
   typedef logic [3:0]                    cfg_type;
   typedef logic [1:0]                    csr_index_type;
   typedef logic [IDX_BITS-1:0]           idx_type;
   typedef logic [ADDR_BITS-1:0]          addr_type;
   typedef logic signed [ELEMENT_BITS-1:0] elem_type;
   typedef logic signed [PROD_BITS-1:0]   prod_type;
   typedef logic signed [OUT_BITS-1:0]    sum_type;

   localparam cmd_type CMD_LOAD_A  = 2'd0;
   localparam cmd_type CMD_LOAD_B  = 2'd1;
   localparam cmd_type CMD_COMPUTE = 2'd2;

   localparam csr_index_type CSR_ROWS_A     = 2'd0;
   localparam csr_index_type CSR_INNER_SIZE = 2'd1;
   localparam csr_index_type CSR_COLS_B     = 2'd2;

   localparam cfg_type CFG_RESET = 4'd8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Highest index in use for a size register: 0 acts as 1, oversize clamps to MAX_DIM
   function automatic idx_type last_index(cfg_type size);
      idx_type result;
      if (size == '0) begin
         result = '0;
      end else if (int'(size) > MAX_DIM) begin
         result = IDX_BITS'(MAX_DIM - 1);
      end else begin
         result = IDX_BITS'(int'(size) - 1);
      end
      return result;
   endfunction

   function automatic addr_type elem_addr(idx_type r, idx_type c);
      return ADDR_BITS'(int'(r) * MAX_DIM + int'(c));
   endfunction

endpackage

// ----- design/mm_req_if.sv -----
`timescale 1ns / 1ps

interface mm_req_if;
   logic                valid;
   logic                ready;
   mm_pkg::cmd_type     command;
   mm_pkg::pos_type     row;
   mm_pkg::pos_type     col;
   mm_pkg::value_type   value;

   modport source (output valid, output command, output row, output col, output value,
                   input ready);
   modport sink   (input valid, input command, input row, input col, input value,
                   output ready);
endinterface

// ----- design/mm_rsp_if.sv -----
`timescale 1ns / 1ps

interface mm_rsp_if;
   logic              valid;
   logic              ready;
   mm_pkg::pos_type   out_row;
   mm_pkg::pos_type   out_col;
   mm_pkg::sum_type   out_value;
   logic              last;

   modport source (output valid, output out_row, output out_col, output out_value,
                   output last, input ready);
   modport sink   (input valid, input out_row, input out_col, input out_value,
                   input last, output ready);
endinterface

// ----- design/matrix_multiply_core.sv -----
`timescale 1ns / 1ps

// Dense matrix product C = A x B on signed Q8.8 elements. A load item (command 0 or 1)
// writes one element of A or B and gives no result; loads outside the store are
// dropped. A compute item walks the product in row-major order and gives one result
// per element: row, column, the exact Q24.16 sum and a last flag on the final one.
// Sizes come from the rows_a, inner_size and cols_b registers (0 acts as 1, larger
// than 8 acts as 8). A compute keeps the request side not ready until its final
// result is in the output register: for each product element it issues inner_size
// reads through the single read port of each element store into the one shared
// multiply-accumulate unit, waits for its pipeline to drain, and hands the sum to
// the output register, later if the result side stalls. The final result may
// wait in the output register while new loads are taken. Elements must be loaded
// before a compute reads them.
module matrix_multiply_core (
   input  logic                  clock,
   input  logic                  reset,
   mm_req_if.sink                req_ch,
   mm_rsp_if.source              rsp_ch,
   input  logic                  csr_write_enable,
   input  mm_pkg::csr_index_type csr_index,
   input  mm_pkg::cfg_type       csr_data
);

   mm_pkg::state_type state_ff, state_in;

   mm_pkg::cfg_type rows_a_ff, inner_size_ff, cols_b_ff;

   mm_pkg::idx_type i_ff, i_in, j_ff, j_in, k_ff, k_in;
   mm_pkg::idx_type lim_r_ff, lim_r_in, lim_k_ff, lim_k_in, lim_c_ff, lim_c_in;

   logic issue;
   logic emit;
   logic pos_last;

   logic req_fire;
   logic load_ok;
   logic a_we, b_we;
   mm_pkg::addr_type wr_addr;
   mm_pkg::elem_type wr_elem;
   mm_pkg::addr_type a_rd_addr, b_rd_addr;
   mm_pkg::elem_type a_q, b_q;

   logic rd_vld_ff, rd_first_ff, rd_last_ff;
   logic mul_vld_ff, mul_first_ff, mul_last_ff;
   mm_pkg::prod_type product_ff, product_in;
   mm_pkg::sum_type  acc_ff, acc_in;

   logic             rsp_vld_ff;
   mm_pkg::pos_type  rsp_row_ff, rsp_col_ff;
   mm_pkg::sum_type  rsp_value_ff;
   logic             rsp_last_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff     <= mm_pkg::CFG_RESET;
         inner_size_ff <= mm_pkg::CFG_RESET;
         cols_b_ff     <= mm_pkg::CFG_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mm_pkg::CSR_ROWS_A:     rows_a_ff     <= csr_data;
            mm_pkg::CSR_INNER_SIZE: inner_size_ff <= csr_data;
            mm_pkg::CSR_COLS_B:     cols_b_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // element loads
   assign req_ch.ready = (state_ff == mm_pkg::ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign load_ok      = req_fire && (int'(req_ch.row) < mm_pkg::MAX_DIM)
                         && (int'(req_ch.col) < mm_pkg::MAX_DIM);
   assign a_we    = load_ok && (req_ch.command == mm_pkg::CMD_LOAD_A);
   assign b_we    = load_ok && (req_ch.command == mm_pkg::CMD_LOAD_B);
   assign wr_addr = mm_pkg::elem_addr(mm_pkg::idx_type'(req_ch.row),
                                      mm_pkg::idx_type'(req_ch.col));
   assign wr_elem = mm_pkg::elem_type'(req_ch.value);

   assign a_rd_addr = mm_pkg::elem_addr(i_ff, k_ff);
   assign b_rd_addr = mm_pkg::elem_addr(k_ff, j_ff);

   mm_ram #(.WIDTH(mm_pkg::ELEMENT_BITS), .DEPTH(mm_pkg::STORE_DEPTH)) u_store_a (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (wr_elem),
      .rd_addr (a_rd_addr),
      .rd_data (a_q)
   );

   mm_ram #(.WIDTH(mm_pkg::ELEMENT_BITS), .DEPTH(mm_pkg::STORE_DEPTH)) u_store_b (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (wr_elem),
      .rd_addr (b_rd_addr),
      .rd_data (b_q)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         lim_r_ff <= '0;
         lim_k_ff <= '0;
         lim_c_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         lim_r_ff <= lim_r_in;
         lim_k_ff <= lim_k_in;
         lim_c_ff <= lim_c_in;
      end
   end

   assign pos_last = (i_ff == lim_r_ff) && (j_ff == lim_c_ff);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      lim_r_in = lim_r_ff;
      lim_k_in = lim_k_ff;
      lim_c_in = lim_c_ff;
      issue    = 1'b0;
      emit     = 1'b0;
      case (state_ff)
         mm_pkg::ST_IDLE: begin
            if (req_fire && req_ch.command == mm_pkg::CMD_COMPUTE) begin
               lim_r_in = mm_pkg::last_index(rows_a_ff);
               lim_k_in = mm_pkg::last_index(inner_size_ff);
               lim_c_in = mm_pkg::last_index(cols_b_ff);
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = mm_pkg::ST_MAC;
            end
         end
         mm_pkg::ST_MAC: begin
            issue = 1'b1;
            if (k_ff == lim_k_ff) begin
               k_in     = '0;
               state_in = mm_pkg::ST_DRAIN;
            end else begin
               k_in = k_ff + mm_pkg::idx_type'(1);
            end
         end
         mm_pkg::ST_DRAIN: begin
            // acc holds the full sum once the last product has been added
            if (mul_vld_ff && mul_last_ff) begin
               state_in = mm_pkg::ST_EMIT;
            end
         end
         mm_pkg::ST_EMIT: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               emit = 1'b1;
               if (pos_last) begin
                  state_in = mm_pkg::ST_IDLE;
               end else begin
                  if (j_ff == lim_c_ff) begin
                     j_in = '0;
                     i_in = i_ff + mm_pkg::idx_type'(1);
                  end else begin
                     j_in = j_ff + mm_pkg::idx_type'(1);
                  end
                  state_in = mm_pkg::ST_MAC;
               end
            end
         end
         default: begin
            state_in = mm_pkg::ST_IDLE;
         end
      endcase
   end

   // multiply-accumulate pipeline: read, multiply, accumulate
   assign product_in = mm_pkg::prod_type'(a_q) * mm_pkg::prod_type'(b_q);
   assign acc_in     = (mul_first_ff ? mm_pkg::sum_type'(0) : acc_ff)
                       + mm_pkg::sum_type'(product_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         mul_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff  <= issue;
         mul_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_first_ff  <= (k_ff == '0);
      rd_last_ff   <= (k_ff == lim_k_ff);
      mul_first_ff <= rd_first_ff;
      mul_last_ff  <= rd_last_ff;
      if (rd_vld_ff) begin
         product_ff <= product_in;
      end
      if (mul_vld_ff) begin
         acc_ff <= acc_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (emit) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_row_ff   <= mm_pkg::pos_type'(i_ff);
         rsp_col_ff   <= mm_pkg::pos_type'(j_ff);
         rsp_value_ff <= acc_ff;
         rsp_last_ff  <= pos_last;
      end
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.out_row   = rsp_row_ff;
   assign rsp_ch.out_col   = rsp_col_ff;
   assign rsp_ch.out_value = rsp_value_ff;
   assign rsp_ch.last      = rsp_last_ff;

   // a new result only ever comes from the emit step
   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(state_ff == mm_pkg::ST_EMIT))
      else $error("result loaded outside emit step");

   // the final product of a sum only lands while draining
   a_sum_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      (mul_vld_ff && mul_last_ff) |-> (state_ff == mm_pkg::ST_DRAIN))
      else $error("accumulator finished outside drain");

   // a run ends only after its flagged final result
   a_run_ends_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mm_pkg::ST_IDLE && $past(state_ff == mm_pkg::ST_EMIT) && !$past(reset))
      |-> rsp_last_ff)
      else $error("run ended without last flag");

endmodule

// ----- design/mm_ram.sv -----
`timescale 1ns / 1ps

module mm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
